[sv/qte_pkg.sv]
// Shared widths and the arctangent table for the quaternion to Euler angle pipeline.
package qte_pkg;

  localparam int unsigned TABLE_LEN = 24;
  localparam int unsigned XW        = 40;  // CORDIC vector width
  localparam int unsigned AW        = 34;  // CORDIC angle accumulator width
  localparam int unsigned OPW       = 35;  // width of the atan2 operands

  typedef logic [31:0] atan_entry_t;

  // atan(2^-i), 2^32 per turn
  localparam atan_entry_t ATAN_LUT [TABLE_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

endpackage

[sv/qte_cordic.sv]
// Pipelined vectoring CORDIC: angle of (x, y), one rotation per register stage.
module qte_cordic #(
  parameter int unsigned NSTEP = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  input  logic signed [qte_pkg::OPW-1:0]       x_i,
  input  logic signed [qte_pkg::OPW-1:0]       y_i,
  output logic                                 valid_o,
  output logic signed [qte_pkg::AW-1:0]        angle_o
);

  localparam int unsigned XW = qte_pkg::XW;
  localparam int unsigned AW = qte_pkg::AW;

  logic                 v_q    [NSTEP+1];
  logic                 zero_q [NSTEP+1];
  logic signed [XW-1:0] x_q    [NSTEP+1];
  logic signed [XW-1:0] y_q    [NSTEP+1];
  logic signed [AW-1:0] acc_q  [NSTEP+1];

  logic signed [XW-1:0] x_ext, y_ext, x_pre_d, y_pre_d;
  logic signed [AW-1:0] acc_pre_d;

  // fold the left half plane onto the right by a quarter turn
  always_comb begin
    x_ext     = XW'(x_i);
    y_ext     = XW'(y_i);
    x_pre_d   = x_ext;
    y_pre_d   = y_ext;
    acc_pre_d = '0;
    if (x_ext < 0) begin
      if (y_ext >= 0) begin
        x_pre_d   = y_ext;
        y_pre_d   = -x_ext;
        acc_pre_d = AW'(64'sd1 <<< 30);
      end else begin
        x_pre_d   = -y_ext;
        y_pre_d   = x_ext;
        acc_pre_d = -AW'(64'sd1 <<< 30);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    zero_q[0] <= (x_i == '0) && (y_i == '0);
    x_q[0]    <= x_pre_d;
    y_q[0]    <= y_pre_d;
    acc_q[0]  <= acc_pre_d;
  end

  for (genvar i = 0; i < NSTEP; i++) begin : g_step
    logic signed [XW-1:0] dx, dy;
    logic signed [AW-1:0] ang;
    assign dx  = x_q[i] >>> i;
    assign dy  = y_q[i] >>> i;
    assign ang = AW'(qte_pkg::ATAN_LUT[i]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else begin
        v_q[i+1] <= v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      zero_q[i+1] <= zero_q[i];
      if (y_q[i] > 0) begin
        x_q[i+1]   <= x_q[i] + dy;
        y_q[i+1]   <= y_q[i] - dx;
        acc_q[i+1] <= acc_q[i] + ang;
      end else begin
        x_q[i+1]   <= x_q[i] - dy;
        y_q[i+1]   <= y_q[i] + dx;
        acc_q[i+1] <= acc_q[i] - ang;
      end
    end
  end

  assign valid_o = v_q[NSTEP];
  assign angle_o = zero_q[NSTEP] ? '0 : acc_q[NSTEP];

endmodule

[sv/quaternion_to_euler_angles.sv]
// Quaternion to roll, pitch and yaw: a fully pipelined datapath, one word per cycle.
// The path from start to valid_o runs through the 29-stage bit-per-stage square root
// and then the pitch CORDIC.
// Throughput: one word per clock; busy is never raised and results cannot be held off.
// Reset clears only the valid bits; datapath registers carry no reset.
module quaternion_to_euler_angles #(
  parameter int unsigned CORDIC_STEPS = 16,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [SAMPLE_WIDTH-1:0] quat_w_i,
  input  logic signed [SAMPLE_WIDTH-1:0] quat_x_i,
  input  logic signed [SAMPLE_WIDTH-1:0] quat_y_i,
  input  logic signed [SAMPLE_WIDTH-1:0] quat_z_i,
  output logic                           valid_o,
  output logic signed [15:0]             roll_angle_o,
  output logic signed [15:0]             pitch_angle_o,
  output logic signed [15:0]             yaw_angle_o,
  output logic                           pitch_clamped_o
);

  localparam int unsigned NSTEP     = (CORDIC_STEPS > qte_pkg::TABLE_LEN) ?
                                      qte_pkg::TABLE_LEN : CORDIC_STEPS;
  localparam int unsigned SQRT_BITS = 29;          // floor sqrt of up to 2^56
  localparam int unsigned NW        = 57;          // radicand width
  localparam int unsigned TW        = NW + 1;      // trial term width
  localparam int unsigned OPW       = qte_pkg::OPW;
  localparam int unsigned AW        = qte_pkg::AW;
  localparam int unsigned RY_DLY    = SQRT_BITS + 2;       // pitch path lead over roll/yaw
  localparam int unsigned CL_DLY    = RY_DLY + NSTEP + 1;  // clamp flag to output stage
  localparam int unsigned LAT       = SQRT_BITS + 7 + NSTEP;

  // the pipeline never stalls
  assign busy = 1'b0;

  // ---------------------------------------------------------------------------
  // Stage 1: bring samples to Q2.14 (floor when narrowing, zero fill when widening)
  // ---------------------------------------------------------------------------
  logic signed [15:0] w_d, x_d, y_d, z_d;
  if (SAMPLE_WIDTH >= 16) begin : g_narrow
    assign w_d = quat_w_i[SAMPLE_WIDTH-1 -: 16];
    assign x_d = quat_x_i[SAMPLE_WIDTH-1 -: 16];
    assign y_d = quat_y_i[SAMPLE_WIDTH-1 -: 16];
    assign z_d = quat_z_i[SAMPLE_WIDTH-1 -: 16];
  end else begin : g_widen
    assign w_d = {quat_w_i, (16-SAMPLE_WIDTH)'(0)};
    assign x_d = {quat_x_i, (16-SAMPLE_WIDTH)'(0)};
    assign y_d = {quat_y_i, (16-SAMPLE_WIDTH)'(0)};
    assign z_d = {quat_z_i, (16-SAMPLE_WIDTH)'(0)};
  end

  logic               v1_q, v2_q, v3_q, v4_q;
  logic signed [15:0] w_q, x_q, y_q, z_q;

  // ---------------------------------------------------------------------------
  // Stage 2: the nine Q.28 products
  // ---------------------------------------------------------------------------
  logic signed [31:0] p_yz_q, p_wx_q, p_xx_q, p_yy_q, p_xy_q, p_wz_q, p_zz_q;
  logic signed [31:0] p_wy_q, p_xz_q;

  // ---------------------------------------------------------------------------
  // Stage 3: atan2 operands and the saturated asin argument
  // ---------------------------------------------------------------------------
  localparam logic signed [OPW-1:0] ONE_Q28 = OPW'(64'sd1 <<< 28);

  logic signed [OPW-1:0] rn_d, rd_d, yn_d, yd_d, s_raw_d;
  logic signed [OPW-1:0] rn_q, rd_q, yn_q, yd_q;
  logic signed [29:0]    s_d, s_q;
  logic                  clamp_d, clamp_q;

  always_comb begin
    rn_d    = OPW'(p_yz_q) + OPW'(p_wx_q);
    rn_d    = rn_d <<< 1;
    rd_d    = ONE_Q28 - ((OPW'(p_xx_q) + OPW'(p_yy_q)) <<< 1);
    yn_d    = OPW'(p_xy_q) + OPW'(p_wz_q);
    yn_d    = yn_d <<< 1;
    yd_d    = ONE_Q28 - ((OPW'(p_yy_q) + OPW'(p_zz_q)) <<< 1);
    s_raw_d = (OPW'(p_wy_q) - OPW'(p_xz_q)) <<< 1;
    clamp_d = 1'b0;
    s_d     = s_raw_d[29:0];
    if (s_raw_d > ONE_Q28) begin
      s_d     = 30'(ONE_Q28);
      clamp_d = 1'b1;
    end else if (s_raw_d < -ONE_Q28) begin
      s_d     = 30'(-ONE_Q28);
      clamp_d = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 4 and 5: s*s from three narrow partial products, then 2^56 - s*s
  // ---------------------------------------------------------------------------
  logic [28:0]        m_d;
  logic [27:0]        pp_hh_q;
  logic [28:0]        pp_hl_q;
  logic [29:0]        pp_ll_q;
  logic signed [29:0] s4_q;
  logic [NW-1:0]      sq_d;

  assign m_d  = s_q[29] ? 29'(-s_q) : s_q[28:0];
  assign sq_d = (NW'(pp_hh_q) << 30) + (NW'(pp_hl_q) << 16) + NW'(pp_ll_q);

  logic [NW-1:0]      sq_r_q    [SQRT_BITS+1];
  logic [SQRT_BITS-1:0] sq_root_q [SQRT_BITS+1];
  logic signed [29:0] sq_s_q    [SQRT_BITS+1];
  logic               sq_v_q    [SQRT_BITS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      v4_q      <= 1'b0;
      sq_v_q[0] <= 1'b0;
    end else begin
      v1_q      <= start && !busy;
      v2_q      <= v1_q;
      v3_q      <= v2_q;
      v4_q      <= v3_q;
      sq_v_q[0] <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q <= w_d;
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;

    p_yz_q <= y_q * z_q;
    p_wx_q <= w_q * x_q;
    p_xx_q <= x_q * x_q;
    p_yy_q <= y_q * y_q;
    p_xy_q <= x_q * y_q;
    p_wz_q <= w_q * z_q;
    p_zz_q <= z_q * z_q;
    p_wy_q <= w_q * y_q;
    p_xz_q <= x_q * z_q;

    rn_q    <= rn_d;
    rd_q    <= rd_d;
    yn_q    <= yn_d;
    yd_q    <= yd_d;
    s_q     <= s_d;
    clamp_q <= clamp_d;

    // split |s| as hi*2^15 + lo; the cross term is doubled by its shift
    pp_hh_q <= m_d[28:15] * m_d[28:15];
    pp_hl_q <= m_d[28:15] * m_d[14:0];
    pp_ll_q <= m_d[14:0] * m_d[14:0];
    s4_q    <= s_q;

    sq_r_q[0]    <= (NW'(1) << 56) - sq_d;
    sq_root_q[0] <= '0;
    sq_s_q[0]    <= s4_q;
  end

  // ---------------------------------------------------------------------------
  // Stages 6..34: restoring square root, one root bit per stage, MSB first
  // ---------------------------------------------------------------------------
  for (genvar j = 0; j < SQRT_BITS; j++) begin : g_sqrt
    localparam int unsigned K = SQRT_BITS - 1 - j;
    logic [TW-1:0] term;
    logic          fits;
    assign term = (TW'(sq_root_q[j]) << (K + 1)) | (TW'(1) << (2 * K));
    assign fits = TW'(sq_r_q[j]) >= term;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[j+1] <= 1'b0;
      end else begin
        sq_v_q[j+1] <= sq_v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      sq_s_q[j+1] <= sq_s_q[j];
      if (fits) begin
        sq_r_q[j+1]    <= NW'(TW'(sq_r_q[j]) - term);
        sq_root_q[j+1] <= sq_root_q[j] | (SQRT_BITS'(1) << K);
      end else begin
        sq_r_q[j+1]    <= sq_r_q[j];
        sq_root_q[j+1] <= sq_root_q[j];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // CORDIC units: roll and yaw start after stage 3, pitch after the square root
  // ---------------------------------------------------------------------------
  logic signed [AW-1:0] roll_acc, yaw_acc, pitch_acc;
  logic                 roll_v, yaw_v, pitch_v;

  qte_cordic #(.NSTEP(NSTEP)) u_roll (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v3_q),
    .x_i     (rd_q),
    .y_i     (rn_q),
    .valid_o (roll_v),
    .angle_o (roll_acc)
  );

  qte_cordic #(.NSTEP(NSTEP)) u_yaw (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v3_q),
    .x_i     (yd_q),
    .y_i     (yn_q),
    .valid_o (yaw_v),
    .angle_o (yaw_acc)
  );

  qte_cordic #(.NSTEP(NSTEP)) u_pitch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_v_q[SQRT_BITS]),
    .x_i     (OPW'(sq_root_q[SQRT_BITS])),
    .y_i     (OPW'(sq_s_q[SQRT_BITS])),
    .valid_o (pitch_v),
    .angle_o (pitch_acc)
  );

  // round half up from 32 to 16 bits, wrapping at pi
  logic [15:0] roll_rnd, yaw_rnd;
  assign roll_rnd = roll_acc[31:16] + 16'(roll_acc[15]);
  assign yaw_rnd  = yaw_acc[31:16] + 16'(yaw_acc[15]);

  // hold roll and yaw until the pitch path catches up
  logic [15:0] roll_dly_q [RY_DLY];
  logic [15:0] yaw_dly_q  [RY_DLY];
  logic        clamp_dly_q [CL_DLY];

  always_ff @(posedge clk_i) begin
    roll_dly_q[0]  <= roll_rnd;
    yaw_dly_q[0]   <= yaw_rnd;
    clamp_dly_q[0] <= clamp_q;
    for (int unsigned i = 1; i < RY_DLY; i++) begin
      roll_dly_q[i] <= roll_dly_q[i-1];
      yaw_dly_q[i]  <= yaw_dly_q[i-1];
    end
    for (int unsigned i = 1; i < CL_DLY; i++) begin
      clamp_dly_q[i] <= clamp_dly_q[i-1];
    end
  end

  // pitch: round half up, then limit to +-pi/2 against CORDIC overshoot
  logic signed [AW-1:0] pitch_sum;
  logic signed [17:0]   pitch_p;
  logic signed [15:0]   pitch_d;

  always_comb begin
    pitch_sum = pitch_acc + AW'(32'sh8000);
    pitch_p   = pitch_sum[AW-1:16];
    if (pitch_p > 18'sd16384) begin
      pitch_d = 16'sd16384;
    end else if (pitch_p < -18'sd16384) begin
      pitch_d = -16'sd16384;
    end else begin
      pitch_d = pitch_p[15:0];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= pitch_v;
    end
  end

  always_ff @(posedge clk_i) begin
    roll_angle_o    <= roll_dly_q[RY_DLY-1];
    yaw_angle_o     <= yaw_dly_q[RY_DLY-1];
    pitch_angle_o   <= pitch_d;
    pitch_clamped_o <= clamp_dly_q[CL_DLY-1];
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_word_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##LAT valid_o)
    else $error("accepted word did not come out after the pipeline latency");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !start |-> ##LAT !valid_o)
    else $error("result strobe without an accepted word");

  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (pitch_angle_o <= 16'sd16384) && (pitch_angle_o >= -16'sd16384))
    else $error("pitch beyond +-pi/2");

  a_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    roll_v == yaw_v)
    else $error("roll and yaw lanes out of step");

endmodule

[tb/sv/tb_quaternion_to_euler_angles.sv]
// Self-checking testbench for the quaternion to Euler angle pipeline.
module tb_quaternion_to_euler_angles;

  localparam int unsigned STEPS   = 16;
  localparam int unsigned SW      = 16;
  localparam longint      ONE_Q28 = 64'sd1 << 28;
  localparam longint      QTURN   = 64'sd1 << 30;
  localparam int          N_RAND  = 1400;
  localparam int          DRAIN   = 60;   // margin past the pipeline latency

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
    logic               clamped;
  } euler_t;

  // Hold the expected angles of every accepted word and compare them in order.
  class euler_scoreboard;
    euler_t pending[$];
    bit     failed;

    // floor(v / 2^s)
    static function longint shr_down(longint v, int s);
      return v >>> s;
    endfunction

    static function longint floor_sqrt(longint unsigned n);
      longint unsigned root, bit_v;
      root  = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > n) bit_v >>= 2;
      while (bit_v != 0) begin
        if (n >= root + bit_v) begin
          n    = n - (root + bit_v);
          root = (root >> 1) + bit_v;
        end else begin
          root = root >> 1;
        end
        bit_v >>= 2;
      end
      return root;
    endfunction

    // Vectoring CORDIC, 2^32 per turn.
    static function longint vector_angle(longint yv, longint xv);
      longint acc, t, dx, dy;
      int n;
      acc = 0;
      n   = (STEPS > qte_pkg::TABLE_LEN) ? qte_pkg::TABLE_LEN : STEPS;
      if (xv == 0 && yv == 0) return 0;
      // Turn left half plane vectors by a quarter turn first.
      if (xv < 0) begin
        t = xv;
        if (yv >= 0) begin
          xv = yv; yv = -t; acc = QTURN;
        end else begin
          xv = -yv; yv = t; acc = -QTURN;
        end
      end
      for (int i = 0; i < n; i++) begin
        dx = shr_down(xv, i);
        dy = shr_down(yv, i);
        if (yv > 0) begin
          xv += dy; yv -= dx; acc += longint'(qte_pkg::ATAN_LUT[i]);
        end else begin
          xv -= dy; yv += dx; acc -= longint'(qte_pkg::ATAN_LUT[i]);
        end
      end
      return acc;
    endfunction

    static function logic [15:0] round_angle(longint a);
      logic [31:0] u;
      u = a[31:0] + 32'h8000;
      return u[31:16];
    endfunction

    static function euler_t predict_euler(logic signed [15:0] w, logic signed [15:0] x,
                                          logic signed [15:0] y, logic signed [15:0] z);
      longint qw, qx, qy, qz, rn, rd, yn, yd, s, c, p;
      euler_t e;
      qw = w; qx = x; qy = y; qz = z;
      rn = 2 * (qy * qz + qw * qx);
      rd = ONE_Q28 - 2 * (qx * qx + qy * qy);
      yn = 2 * (qx * qy + qw * qz);
      yd = ONE_Q28 - 2 * (qy * qy + qz * qz);
      s  = 2 * (qw * qy - qx * qz);
      e.clamped = 1'b0;
      if (s > ONE_Q28) begin
        s = ONE_Q28; e.clamped = 1'b1;
      end
      if (s < -ONE_Q28) begin
        s = -ONE_Q28; e.clamped = 1'b1;
      end
      c = floor_sqrt(ONE_Q28 * ONE_Q28 - s * s);
      p = shr_down(vector_angle(s, c) + 64'sh8000, 16);
      if (p > 16384) p = 16384;
      if (p < -16384) p = -16384;
      e.roll  = round_angle(vector_angle(rn, rd));
      e.pitch = p[15:0];
      e.yaw   = round_angle(vector_angle(yn, yd));
      return e;
    endfunction

    function void note_word(logic signed [15:0] w, logic signed [15:0] x,
                            logic signed [15:0] y, logic signed [15:0] z);
      pending.push_back(predict_euler(w, x, y, z));
    endfunction

    function void check_word(euler_t got);
      euler_t exp_e;
      if (pending.size() == 0) begin
        $error("result with nothing outstanding: roll %0d pitch %0d yaw %0d",
               got.roll, got.pitch, got.yaw);
        failed = 1;
        return;
      end
      exp_e = pending.pop_front();
      if (got.roll !== exp_e.roll) begin
        $error("roll_angle: expected %0d actual %0d", exp_e.roll, got.roll);
        failed = 1;
      end
      if (got.pitch !== exp_e.pitch) begin
        $error("pitch_angle: expected %0d actual %0d", exp_e.pitch, got.pitch);
        failed = 1;
      end
      if (got.yaw !== exp_e.yaw) begin
        $error("yaw_angle: expected %0d actual %0d", exp_e.yaw, got.yaw);
        failed = 1;
      end
      if (got.clamped !== exp_e.clamped) begin
        $error("pitch_clamped: expected %0b actual %0b", exp_e.clamped, got.clamped);
        failed = 1;
      end
    endfunction
  endclass

  logic                  clk_i, rst_ni, start, busy, valid_o, pitch_clamped_o;
  logic signed [SW-1:0]  quat_w_i, quat_x_i, quat_y_i, quat_z_i;
  logic signed [15:0]    roll_angle_o, pitch_angle_o, yaw_angle_o;
  bit                    idle_on;

  euler_scoreboard sb = new();

  quaternion_to_euler_angles #(.CORDIC_STEPS(STEPS), .SAMPLE_WIDTH(SW)) dut (.*);

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // Sample results at the edge that ends their cycle.
  always @(posedge clk_i) begin
    if (rst_ni && valid_o)
      sb.check_word('{roll_angle_o, pitch_angle_o, yaw_angle_o, pitch_clamped_o});
  end

  // Drop start for a random burst of idle cycles.
  task automatic idle_burst();
    int n;
    n = $urandom_range(19, 1);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Present one word and hold it until the block takes it.
  task automatic send_word(logic signed [15:0] w, logic signed [15:0] x,
                           logic signed [15:0] y, logic signed [15:0] z);
    if (idle_on && $urandom_range(3, 0) == 0) idle_burst();
    start    <= 1'b1;
    quat_w_i <= w;
    quat_x_i <= x;
    quat_y_i <= y;
    quat_z_i <= z;
    do @(posedge clk_i); while (busy);
    sb.note_word(w, x, y, z);
  endtask

  // Wait with start low until every outstanding word has come back.
  task automatic drain_all();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_random(int count);
    logic signed [15:0] q[4];
    for (int i = 0; i < count; i++) begin
      for (int k = 0; k < 4; k++) begin
        case ($urandom_range(3, 0))
          0:       q[k] = 16'($urandom);                          // any value
          1:       q[k] = 16'($urandom_range(32767, 0) - 16384);  // near unit range
          2:       q[k] = 16'($urandom_range(16384, 0));
          default: q[k] = 16'($urandom_range(2000, 0) - 1000);
        endcase
      end
      send_word(q[0], q[1], q[2], q[3]);
    end
  endtask

  initial begin
    rst_ni   = 1'b0;
    start    = 1'b0;
    quat_w_i = '0;
    quat_x_i = '0;
    quat_y_i = '0;
    quat_z_i = '0;
    idle_on  = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words: extremes, identity, gimbal lock and the zero vector.
    send_word(0, 0, 0, 0);
    send_word(16384, 0, 0, 0);
    send_word(-16384, 0, 0, 0);
    send_word(0, 16384, 0, 0);
    send_word(0, 0, 16384, 0);
    send_word(0, 0, 0, 16384);
    send_word(32767, 32767, 32767, 32767);
    send_word(-32768, -32768, -32768, -32768);
    send_word(-32768, 32767, -32768, 32767);
    send_word(32767, -32768, 32767, -32768);
    send_word(11585, 0, 11585, 0);    // pitch at +pi/2, just inside
    send_word(11586, 0, 11586, 0);    // asin argument saturates high
    send_word(11586, 0, -11586, 0);   // saturates low
    send_word(0, 11586, 0, 11586);
    send_word(0, 8192, 8192, 0);      // roll of the zero vector
    send_word(0, 0, 8192, 8192);      // yaw of the zero vector
    send_word(0, 16384, 100, 0);      // roll operand in left half plane
    send_word(0, 16384, -100, 0);
    send_word(100, 0, 0, 16384);
    send_word(-100, 0, 0, 16384);
    send_word(1, -1, 1, -1);
    send_word(14189, 4096, 4096, 4096);
    drain_all();

    // Random words with idle bursts, a full pause, more with idle bursts, then a burst with no idling.
    idle_on = 1'b1;
    send_random(N_RAND / 2);
    drain_all();
    send_random(N_RAND / 4);
    idle_on = 1'b0;
    send_random(N_RAND / 4);
    start <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (!sb.failed) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
